/* sv/mesh_vertex_split_by_attribute_defines.svh */
// Assertion macros shared by the vertex split checker.
`ifndef MESH_VERTEX_SPLIT_BY_ATTRIBUTE_DEFINES_SVH
`define MESH_VERTEX_SPLIT_BY_ATTRIBUTE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MVSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define MVSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mvsa_pkg.sv */
// Types and constants of the mesh vertex split block.
package mvsa_pkg;

  localparam int EPOCH_W = 8;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_CORNER = 1'b1;

  typedef enum logic {
    OP_START,
    OP_CORNER
  } op_e;

  typedef struct packed {
    logic        kind;
    logic [11:0] vertex_index;
    logic [15:0] attr_index;
    logic [12:0] vertex_count;
  } in_item_t;

  typedef struct packed {
    logic [11:0] new_vertex_index;
    logic        made_copy;
    logic [11:0] copy_source;
    logic        overflow;
    logic [12:0] total_vertices;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [11:0] vertex_index;
    logic [15:0] attr_index;
    logic [12:0] vertex_count;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

endpackage

/* sv/mvsa_ram.sv */
// Generic simple dual-port RAM with registered read.
module mvsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mvsa_front.sv */
// Input side: accepts items, decodes their kind and queues them for the back end.
module mvsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mvsa_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  output mvsa_pkg::cmd_t    q_cmd_o,
  input  mvsa_pkg::bk_ctl_t bk_ctl_i
);
  import mvsa_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd;

  always_comb begin
    cmd.vertex_index = in_item_i.vertex_index;
    cmd.attr_index   = in_item_i.attr_index;
    cmd.vertex_count = in_item_i.vertex_count;
    case (in_item_i.kind)
      KIND_START:  cmd.op = OP_START;
      KIND_CORNER: cmd.op = OP_CORNER;
      default:     cmd.op = OP_CORNER;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2) || bk_ctl_i.clearing;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = bk_ctl_i.pop && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/mvsa_back.sv */
// Back end: walks duplicate chains in the vertex and link memories and registers results.
module mvsa_back #(
  parameter int MAX_VERTS = 4096,
  parameter int ATTR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mvsa_pkg::cmd_t     q_cmd_i,
  output mvsa_pkg::bk_ctl_t  bk_ctl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mvsa_pkg::out_item_t out_item_o
);
  import mvsa_pkg::*;

  localparam int IW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int VW = EPOCH_W + ATTR_BITS;
  localparam int LW = EPOCH_W + IW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK0,
    S_STEP,
    S_ALLOC,
    S_LINK,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [IW-1:0]        clr_q;
  logic [EPOCH_W-1:0]   epoch_q;
  logic                 wrap_q;
  logic [CW-1:0]        total_q;
  logic [11:0]          cur_vin_q;
  logic [IW-1:0]        cur_v_q;
  logic [ATTR_BITS-1:0] cur_a_q;
  logic [IW-1:0]        last_q;
  logic [IW-1:0]        cand_q;
  logic [11:0]          res_idx_q;
  logic                 res_copy_q;
  logic [11:0]          res_src_q;
  logic                 res_ovf_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  logic                 v_we, l_we;
  logic [IW-1:0]        v_waddr, l_waddr, raddr;
  logic [VW-1:0]        v_wdata, v_rdata;
  logic [LW-1:0]        l_wdata, l_rdata;
  logic [EPOCH_W-1:0]   vr_tag, lr_tag;
  logic [ATTR_BITS-1:0] vr_attr;
  logic [IW-1:0]        lr_next;
  logic                 vr_seen, lr_has;
  logic [31:0]          qv_ext, qa_ext, qc_ext, cand_ext, total_ext, tot_next_ext;
  logic                 out_free;

  assign vr_tag  = v_rdata[VW-1 -: EPOCH_W];
  assign vr_attr = v_rdata[ATTR_BITS-1:0];
  assign lr_tag  = l_rdata[LW-1 -: EPOCH_W];
  assign lr_next = l_rdata[IW-1:0];
  assign vr_seen = (vr_tag == epoch_q);
  assign lr_has  = (lr_tag == epoch_q);

  assign qv_ext       = 32'(q_cmd_i.vertex_index);
  assign qa_ext       = 32'(q_cmd_i.attr_index);
  assign qc_ext       = 32'(q_cmd_i.vertex_count);
  assign cand_ext     = 32'(cand_q);
  assign total_ext    = 32'(total_q);
  assign tot_next_ext = 32'(total_q);
  assign out_free     = !out_valid_q || !out_stall_i;

  assign bk_ctl_o.pop      = (state_q == S_IDLE) && q_valid_i;
  assign bk_ctl_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    v_we    = 1'b0;
    v_waddr = cur_v_q;
    v_wdata = {epoch_q, cur_a_q};
    l_we    = 1'b0;
    l_waddr = last_q;
    l_wdata = {epoch_q, total_q[IW-1:0]};
    raddr   = lr_next;
    case (state_q)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_q;
        v_wdata = '0;
        l_we    = 1'b1;
        l_waddr = clr_q;
        l_wdata = '0;
      end
      S_IDLE: begin
        raddr = qv_ext[IW-1:0];
      end
      S_CHK0: begin
        v_we = !vr_seen;
      end
      S_ALLOC: begin
        v_we    = (total_q != CW'(MAX_VERTS));
        v_waddr = total_q[IW-1:0];
      end
      S_LINK: begin
        l_we = 1'b1;
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  mvsa_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_vram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (raddr),
    .rdata_o (v_rdata)
  );

  mvsa_ram #(.WIDTH(LW), .DEPTH(MAX_VERTS)) u_lram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (raddr),
    .rdata_o (l_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      epoch_q     <= EPOCH_W'(1);
      wrap_q      <= 1'b0;
      total_q     <= '0;
      cur_vin_q   <= '0;
      cur_v_q     <= '0;
      cur_a_q     <= '0;
      last_q      <= '0;
      cand_q      <= '0;
      res_idx_q   <= '0;
      res_copy_q  <= 1'b0;
      res_src_q   <= '0;
      res_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_q == IW'(MAX_VERTS - 1)) begin
            clr_q   <= '0;
            epoch_q <= EPOCH_W'(1);
            wrap_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            cur_vin_q  <= q_cmd_i.vertex_index;
            cur_v_q    <= qv_ext[IW-1:0];
            cur_a_q    <= qa_ext[ATTR_BITS-1:0];
            last_q     <= qv_ext[IW-1:0];
            res_copy_q <= 1'b0;
            res_src_q  <= '0;
            res_ovf_q  <= 1'b0;
            case (q_cmd_i.op)
              OP_START: begin
                res_idx_q <= '0;
                if (qc_ext > 32'(MAX_VERTS)) begin
                  total_q <= CW'(MAX_VERTS);
                end else begin
                  total_q <= qc_ext[CW-1:0];
                end
                if (epoch_q == '1) begin
                  wrap_q <= 1'b1;
                end else begin
                  epoch_q <= epoch_q + 1'b1;
                end
                state_q <= S_OUT;
              end
              default: begin
                res_idx_q <= q_cmd_i.vertex_index;
                if (qv_ext < total_ext) begin
                  state_q <= S_CHK0;
                end else begin
                  state_q <= S_OUT;
                end
              end
            endcase
          end
        end
        S_CHK0: begin
          if (!vr_seen || (vr_attr == cur_a_q)) begin
            state_q <= S_OUT;
          end else if (lr_has) begin
            cand_q  <= lr_next;
            state_q <= S_STEP;
          end else begin
            state_q <= S_ALLOC;
          end
        end
        S_STEP: begin
          if (vr_seen && (vr_attr == cur_a_q)) begin
            res_idx_q <= cand_ext[11:0];
            state_q   <= S_OUT;
          end else begin
            last_q <= cand_q;
            if (lr_has) begin
              cand_q <= lr_next;
            end else begin
              state_q <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          if (total_q == CW'(MAX_VERTS)) begin
            res_ovf_q <= 1'b1;
            res_idx_q <= cur_vin_q;
            state_q   <= S_OUT;
          end else begin
            res_idx_q  <= total_ext[11:0];
            res_copy_q <= 1'b1;
            res_src_q  <= cur_vin_q;
            state_q    <= S_LINK;
          end
        end
        S_LINK: begin
          total_q <= total_q + 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_item_q.new_vertex_index <= res_idx_q;
            out_item_q.made_copy        <= res_copy_q;
            out_item_q.copy_source      <= res_src_q;
            out_item_q.overflow         <= res_ovf_q;
            out_item_q.total_vertices   <= tot_next_ext[12:0];
            state_q                     <= wrap_q ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* sv/mesh_vertex_split_by_attribute.sv */
// Mesh vertex split by attribute: rewrites face corner vertex indices so every vertex
// carries one attribute, allocating duplicates at the vertex count. A start item, and a
// corner whose index is not below the vertex count, go from idle straight to output. Any
// other corner checks its vertex entry and, when the vertex needs a split, walks the
// duplicates in its chain; if none matches it allocates and links a new duplicate, or
// flags overflow when the store is full. A result held by the output stall holds the
// back end until it is taken. The chain walk is bounded by the registered read of the
// vertex and link memories, one chain entry per cycle. Pass marks are epoch tags; after
// reset and after every 255th start item a clearing pass runs over all MAX_VERTS
// entries, during which no item is taken. A two-entry queue in front lets input be taken
// while the back end works or its result is stalled.
module mesh_vertex_split_by_attribute #(
  parameter int MAX_VERTS = 4096,
  parameter int ATTR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mvsa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mvsa_pkg::out_item_t out_item_o
);
  import mvsa_pkg::*;

  logic    q_valid;
  cmd_t    q_cmd;
  bk_ctl_t bk_ctl;

  mvsa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .bk_ctl_i   (bk_ctl)
  );

  mvsa_back #(.MAX_VERTS(MAX_VERTS), .ATTR_BITS(ATTR_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .bk_ctl_o    (bk_ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* sv/mvsa_checker.sv */
// Port-level checker for the vertex split block and its bind.
`include "mesh_vertex_split_by_attribute_defines.svh"

module mvsa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mvsa_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mvsa_pkg::out_item_t out_item_o
);
  import mvsa_pkg::*;

  `MVSA_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(in_item_i), "stalled input item changed")
  `MVSA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o), "stalled result changed")
  `MVSA_ASSERT_NOW(a_copy_no_ovf, out_valid_o,
    !(out_item_o.made_copy && out_item_o.overflow), "copy and overflow together")
  `MVSA_ASSERT_NOW(a_copy_is_last, out_valid_o && out_item_o.made_copy,
    out_item_o.new_vertex_index == 12'(out_item_o.total_vertices - 13'd1),
    "copy index is not the last vertex")
  `MVSA_ASSERT_NOW(a_src_zero, out_valid_o && !out_item_o.made_copy,
    out_item_o.copy_source == 12'd0, "copy source set without copy")

endmodule

bind mesh_vertex_split_by_attribute mvsa_checker u_mvsa_checker (.*);

/* tb/sv/tb_mesh_vertex_split_by_attribute.sv */
// Self-checking testbench for the mesh vertex split block: directed table, random passes.
module tb_mesh_vertex_split_by_attribute;
  timeunit 1ns;
  timeprecision 1ps;

  import mvsa_pkg::*;

  localparam int MAX_VERTS    = 4096;
  localparam int ATTR_BITS    = 16;
  localparam int ITEM_TARGET  = 1350;
  localparam int BRIEF_PASSES = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT_CYCLES = 1000000;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  logic [15:0] vertex_attr [MAX_VERTS];
  bit          seen_mark   [MAX_VERTS];
  logic [11:0] dup_link    [MAX_VERTS];
  bit          link_valid  [MAX_VERTS];
  int unsigned vertex_total = 0;

  out_item_t   expected_remaps [$];
  out_item_t   want_item;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          starts_sent = 0;
  int          burst_left = 0;
  bit          hold_request = 1'b0;
  stim_row_t   directed_tbl [25];

  mesh_vertex_split_by_attribute #(
    .MAX_VERTS(MAX_VERTS),
    .ATTR_BITS(ATTR_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic out_item_t split_vertex(in_item_t it);
    out_item_t   r;
    int unsigned v;
    int unsigned last;
    int unsigned nx;
    int unsigned steps;
    bit          found;
    r = '0;
    v = it.vertex_index;
    r.new_vertex_index = it.vertex_index;
    if (it.kind == KIND_START) begin
      for (int i = 0; i < MAX_VERTS; i++) begin
        seen_mark[i] = 1'b0;
        link_valid[i] = 1'b0;
      end
      vertex_total = (it.vertex_count > MAX_VERTS) ? MAX_VERTS : it.vertex_count;
      r.new_vertex_index = '0;
    end else if (v < vertex_total && !seen_mark[v]) begin
      seen_mark[v] = 1'b1;
      vertex_attr[v] = it.attr_index;
    end else if (v < vertex_total && vertex_attr[v] != it.attr_index) begin
      last = v;
      found = 1'b0;
      steps = 0;
      while (link_valid[last] && !found && steps < MAX_VERTS) begin
        nx = dup_link[last];
        if (seen_mark[nx] && vertex_attr[nx] == it.attr_index) begin
          found = 1'b1;
          r.new_vertex_index = 12'(nx);
        end else begin
          last = nx;
          steps++;
        end
      end
      if (!found && vertex_total >= MAX_VERTS) begin
        r.overflow = 1'b1;
      end else if (!found) begin
        seen_mark[vertex_total] = 1'b1;
        vertex_attr[vertex_total] = it.attr_index;
        link_valid[vertex_total] = 1'b0;
        dup_link[last] = 12'(vertex_total);
        link_valid[last] = 1'b1;
        r.new_vertex_index = 12'(vertex_total);
        r.made_copy = 1'b1;
        r.copy_source = it.vertex_index;
        vertex_total++;
      end
    end
    r.total_vertices = 13'(vertex_total);
    return r;
  endfunction

  function automatic stim_row_t row(logic k, int v, int a, int c, bit typed,
                                    int nv, int mc, int src, int ovf, int tot);
    stim_row_t s;
    s.item.kind = k;
    s.item.vertex_index = 12'(v);
    s.item.attr_index = 16'(a);
    s.item.vertex_count = 13'(c);
    s.typed = typed;
    s.want.new_vertex_index = 12'(nv);
    s.want.made_copy = 1'(mc);
    s.want.copy_source = 12'(src);
    s.want.overflow = 1'(ovf);
    s.want.total_vertices = 13'(tot);
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // one item through the input handshake; the sender may idle between bursts
  task automatic offer(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    int        gap;
    if (burst_left == 0) begin
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = split_vertex(it);
    expected_remaps.insert(expected_remaps.size(), typed ? want : pred);
    items_sent++;
  endtask

  task automatic run_pass(bit brief);
    in_item_t it;
    int       cnt;
    int       eff;
    int       lo;
    int       n;
    int       v;
    int       attr_base;
    cnt = 0;
    case ($urandom_range(0, 5))
      0: cnt = $urandom_range(0, 3);
      1, 2: cnt = $urandom_range(4, 24);
      3: cnt = $urandom_range(4080, 4096);
      4: cnt = $urandom_range(4097, 8191);
      default: cnt = $urandom_range(0, 8191);
    endcase
    eff = (cnt > MAX_VERTS) ? MAX_VERTS : cnt;
    lo = 0;
    if (eff > 8) begin
      lo = $urandom_range(0, 1) ? eff - 8 : $urandom_range(0, eff - 8);
    end
    attr_base = $urandom_range(0, 65535);
    it.kind = KIND_START;
    it.vertex_index = 12'($urandom_range(0, 4095));
    it.attr_index = 16'($urandom_range(0, 65535));
    it.vertex_count = 13'(cnt);
    offer(it, 1'b0, '0);
    starts_sent++;
    if (brief) begin
      n = $urandom_range(0, 3);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(4, 16);
    end
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, 4095);
        1: v = (vertex_total > eff) ? $urandom_range(eff, vertex_total - 1) : lo;
        default: v = lo + $urandom_range(0, 7);
      endcase
      it.kind = KIND_CORNER;
      it.vertex_index = 12'(v);
      it.attr_index = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'(attr_base ^ $urandom_range(0, 3));
      it.vertex_count = 13'($urandom_range(0, 8191));
      offer(it, 1'b0, '0);
    end
  endtask

  initial begin
    rx_mode_e mode;
    int       span;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          out_stall_i <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            RX_OPEN:   out_stall_i <= 1'b0;
            RX_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
            RX_TOGGLE: out_stall_i <= ~out_stall_i;
            default:   out_stall_i <= 1'b0;
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_remaps.size() == 0) begin
        report_mismatch("unexpected result, new_vertex_index", out_item_o.new_vertex_index, -1);
      end else begin
        want_item = expected_remaps.pop_front();
        if (out_item_o.new_vertex_index !== want_item.new_vertex_index)
          report_mismatch("new_vertex_index", out_item_o.new_vertex_index,
                          want_item.new_vertex_index);
        if (out_item_o.made_copy !== want_item.made_copy)
          report_mismatch("made_copy", out_item_o.made_copy, want_item.made_copy);
        if (out_item_o.copy_source !== want_item.copy_source)
          report_mismatch("copy_source", out_item_o.copy_source, want_item.copy_source);
        if (out_item_o.overflow !== want_item.overflow)
          report_mismatch("overflow", out_item_o.overflow, want_item.overflow);
        if (out_item_o.total_vertices !== want_item.total_vertices)
          report_mismatch("total_vertices", out_item_o.total_vertices,
                          want_item.total_vertices);
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_VERTS; i++) begin
      seen_mark[i] = 1'b0;
      link_valid[i] = 1'b0;
    end
    directed_tbl = '{
      row(KIND_START,     0, 16'h0000,    0, 1,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    0, 16'h0000,    0, 1,    0, 0,    0, 0,    0),
      row(KIND_CORNER, 4095, 16'hFFFF, 8191, 1, 4095, 0,    0, 0,    0),
      row(KIND_START,     0, 16'h0000, 8191, 1,    0, 0,    0, 0, 4096),
      row(KIND_CORNER, 4095, 16'hFFFF,    0, 1, 4095, 0,    0, 0, 4096),
      row(KIND_CORNER, 4095, 16'h0000,    0, 1, 4095, 0,    0, 1, 4096),
      row(KIND_CORNER, 4095, 16'hFFFF,    0, 1, 4095, 0,    0, 0, 4096),
      row(KIND_START,     0, 16'h0000, 4096, 1,    0, 0,    0, 0, 4096),
      row(KIND_START,     0, 16'h0000,    4, 1,    0, 0,    0, 0,    4),
      row(KIND_CORNER,    0, 16'h0005,    0, 1,    0, 0,    0, 0,    4),
      row(KIND_CORNER,    0, 16'h0006,    0, 1,    4, 1,    0, 0,    5),
      row(KIND_CORNER,    0, 16'h0007,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    0, 16'h0006,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    0, 16'h0007,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    4, 16'h0009,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    0, 16'h0009,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    3, 16'hFFFF,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_CORNER,    7, 16'h0000,    0, 0,    0, 0,    0, 0,    0),
      row(KIND_START,     0, 16'h0000, 4095, 1,    0, 0,    0, 0, 4095),
      row(KIND_CORNER, 4094, 16'h0001,    0, 1, 4094, 0,    0, 0, 4095),
      row(KIND_CORNER, 4094, 16'h0002,    0, 1, 4095, 1, 4094, 0, 4096),
      row(KIND_CORNER, 4094, 16'h0003,    0, 1, 4094, 0,    0, 1, 4096),
      row(KIND_CORNER, 4095, 16'h0002,    0, 1, 4095, 0,    0, 0, 4096),
      row(KIND_START,  4095, 16'hFFFF, 4097, 1,    0, 0,    0, 0, 4096),
      row(KIND_CORNER, 4095, 16'h0000,    0, 1, 4095, 0,    0, 0, 4096)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i]) begin
      offer(directed_tbl[i].item, directed_tbl[i].typed, directed_tbl[i].want);
    end

    hold_request = 1'b1;
    while (starts_sent < BRIEF_PASSES) run_pass(1'b1);
    hold_request = 1'b1;
    while (items_sent < ITEM_TARGET) run_pass(1'b0);
    in_valid_i <= 1'b0;

    while (expected_remaps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* mesh_vertex_split_by_attribute.f */
+incdir+sv
sv/mvsa_pkg.sv
sv/mvsa_ram.sv
sv/mvsa_front.sv
sv/mvsa_back.sv
sv/mesh_vertex_split_by_attribute.sv
sv/mvsa_checker.sv
tb/sv/tb_mesh_vertex_split_by_attribute.sv
